/* rtl/core/priority_audio_cue_command_controller_defines.svh */
// Assertion macros shared by the controller RTL.
`ifndef PRIORITY_AUDIO_CUE_COMMAND_CONTROLLER_DEFINES_SVH
`define PRIORITY_AUDIO_CUE_COMMAND_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PACC_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("pacc assertion failed");

// Next-cycle implication, checked outside reset.
`define PACC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("pacc assertion failed");

`endif

/* rtl/core/pacc_pkg.sv */
`default_nettype none

package pacc_pkg;

   localparam logic [2:0] OP_PLAY   = 3'd0;
   localparam logic [2:0] OP_CLICK  = 3'd1;
   localparam logic [2:0] OP_STOP   = 3'd2;
   localparam logic [2:0] OP_VOLUME = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;
   localparam logic [2:0] OP_RX     = 3'd5;

   localparam logic [2:0] CSR_LINK_OK        = 3'd0;
   localparam logic [2:0] CSR_CLICK_TRACK    = 3'd1;
   localparam logic [2:0] CSR_CLICK_PRIORITY = 3'd2;
   localparam logic [2:0] CSR_LONG_TIMEOUT   = 3'd3;
   localparam logic [2:0] CSR_SHORT_TIMEOUT  = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0] FRAME_START   = 8'h7E;
   localparam logic [7:0] FRAME_VERSION = 8'hFF;
   localparam logic [7:0] FRAME_LENGTH  = 8'h06;
   localparam logic [7:0] FRAME_END     = 8'hEF;
   localparam logic [7:0] FRAME_FEEDBACK = 8'h00;

   localparam logic [7:0] CMD_VOLUME = 8'h06;
   localparam logic [7:0] CMD_PLAY   = 8'h12;
   localparam logic [7:0] CMD_STOP   = 8'h16;
   localparam logic [7:0] CMD_FINISH = 8'h3D;

   localparam logic [4:0]  VOLUME_MAX     = 5'd30;
   localparam logic [4:0]  DEFAULT_VOLUME = 5'd20;
   localparam logic [15:0] LONG_TIMEOUT_RESET  = 16'd4000;
   localparam logic [15:0] SHORT_TIMEOUT_RESET = 16'd250;
   localparam logic [7:0]  CLICK_TRACK_RESET   = 8'd1;

   localparam logic [3:0] FRAME_LAST_INDEX = 4'd9;
   localparam logic [3:0] RX_BODY_CMD      = 4'd3;
   localparam logic [3:0] RX_BODY_LAST     = 4'd9;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] track;
      logic [7:0] priority_req;
      logic [7:0] level;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] lsb;
      logic       last;
   } frame_desc_type;

   typedef struct packed {
      logic           valid0;
      frame_desc_type desc0;
      logic           valid1;
      frame_desc_type desc1;
   } frame_push_type;

   function automatic logic [15:0] frame_checksum(input logic [7:0] cmd,
                                                  input logic [7:0] lsb);
      logic [15:0] sum;
      sum = {8'h00, FRAME_VERSION} + {8'h00, FRAME_LENGTH} + {8'h00, cmd}
            + {8'h00, FRAME_FEEDBACK} + {8'h00, lsb};
      return 16'h0000 - sum;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/pacc_front.sv */
`default_nettype none

module pacc_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pacc_pkg::req_word_type              req_word,
   input  wire logic                                csr_write_en,
   input  wire logic [pacc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pacc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                queue_room,
   output pacc_pkg::frame_push_type                 push
);

   logic        link_ok_ff, link_ok_in;
   logic [7:0]  click_track_ff, click_track_in;
   logic [7:0]  click_priority_ff, click_priority_in;
   logic [15:0] long_timeout_ff, long_timeout_in;
   logic [15:0] short_timeout_ff, short_timeout_in;

   logic        playing_ff, playing_in;
   logic [7:0]  cur_priority_ff, cur_priority_in;
   logic [4:0]  volume_ff, volume_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        short_active_ff, short_active_in;
   logic [3:0]  rx_count_ff, rx_count_in;
   logic        rx_finish_ff, rx_finish_in;

   logic        accept;
   logic        can_play;
   logic [4:0]  level_clamped;
   logic [15:0] limit;
   logic [15:0] elapsed_next;

   assign req_ready = queue_room;
   assign accept = req_valid && queue_room;
   assign can_play = link_ok_ff && (volume_ff != 5'd0);
   assign level_clamped = (req_word.level > {3'b000, pacc_pkg::VOLUME_MAX}) ?
                          pacc_pkg::VOLUME_MAX : req_word.level[4:0];
   assign limit = short_active_ff ? short_timeout_ff : long_timeout_ff;
   assign elapsed_next = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   always_comb begin
      link_ok_in = link_ok_ff;
      click_track_in = click_track_ff;
      click_priority_in = click_priority_ff;
      long_timeout_in = long_timeout_ff;
      short_timeout_in = short_timeout_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            pacc_pkg::CSR_LINK_OK:        link_ok_in = csr_wdata[0];
            pacc_pkg::CSR_CLICK_TRACK:    click_track_in = csr_wdata[7:0];
            pacc_pkg::CSR_CLICK_PRIORITY: click_priority_in = csr_wdata[7:0];
            pacc_pkg::CSR_LONG_TIMEOUT:   long_timeout_in = csr_wdata;
            pacc_pkg::CSR_SHORT_TIMEOUT:  short_timeout_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      playing_in = playing_ff;
      cur_priority_in = cur_priority_ff;
      volume_in = volume_ff;
      elapsed_in = elapsed_ff;
      short_active_in = short_active_ff;
      rx_count_in = rx_count_ff;
      rx_finish_in = rx_finish_ff;
      push = '0;
      if (accept) begin
         unique case (req_word.op)
            pacc_pkg::OP_PLAY: begin
               if (can_play) begin
                  short_active_in = 1'b0;
                  if (!playing_ff || (req_word.priority_req > cur_priority_ff)) begin
                     if (playing_ff) begin
                        push.valid0 = 1'b1;
                        push.desc0 = '{cmd: pacc_pkg::CMD_STOP, lsb: 8'h00, last: 1'b0};
                        push.valid1 = 1'b1;
                        push.desc1 = '{cmd: pacc_pkg::CMD_PLAY, lsb: req_word.track,
                                       last: 1'b1};
                     end else begin
                        push.valid0 = 1'b1;
                        push.desc0 = '{cmd: pacc_pkg::CMD_PLAY, lsb: req_word.track,
                                       last: 1'b1};
                     end
                     playing_in = 1'b1;
                     cur_priority_in = req_word.priority_req;
                     elapsed_in = 16'd0;
                  end
               end
            end
            pacc_pkg::OP_CLICK: begin
               if (can_play && !playing_ff) begin
                  push.valid0 = 1'b1;
                  push.desc0 = '{cmd: pacc_pkg::CMD_PLAY, lsb: click_track_ff, last: 1'b1};
                  playing_in = 1'b1;
                  cur_priority_in = click_priority_ff;
                  elapsed_in = 16'd0;
                  short_active_in = 1'b1;
               end
            end
            pacc_pkg::OP_STOP: begin
               push.valid0 = 1'b1;
               push.desc0 = '{cmd: pacc_pkg::CMD_STOP, lsb: 8'h00, last: 1'b1};
               playing_in = 1'b0;
               cur_priority_in = 8'h00;
            end
            pacc_pkg::OP_VOLUME: begin
               volume_in = level_clamped;
               if (link_ok_ff) begin
                  push.valid0 = 1'b1;
                  push.desc0 = '{cmd: pacc_pkg::CMD_VOLUME, lsb: {3'b000, level_clamped},
                                 last: 1'b1};
               end
            end
            pacc_pkg::OP_TICK: begin
               if (playing_ff) begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= limit) begin
                     playing_in = 1'b0;
                     cur_priority_in = 8'h00;
                  end
               end
            end
            pacc_pkg::OP_RX: begin
               if (rx_count_ff == 4'd0) begin
                  if (req_word.rx_byte == pacc_pkg::FRAME_START) begin
                     rx_count_in = 4'd1;
                     rx_finish_in = 1'b0;
                  end
               end else begin
                  if (rx_count_ff == pacc_pkg::RX_BODY_CMD) begin
                     rx_finish_in = (req_word.rx_byte == pacc_pkg::CMD_FINISH);
                  end
                  if (rx_count_ff >= pacc_pkg::RX_BODY_LAST) begin
                     if (rx_finish_ff) begin
                        playing_in = 1'b0;
                        cur_priority_in = 8'h00;
                     end
                     rx_count_in = 4'd0;
                     rx_finish_in = 1'b0;
                  end else begin
                     rx_count_in = rx_count_ff + 4'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ok_ff <= 1'b0;
         click_track_ff <= pacc_pkg::CLICK_TRACK_RESET;
         click_priority_ff <= 8'h00;
         long_timeout_ff <= pacc_pkg::LONG_TIMEOUT_RESET;
         short_timeout_ff <= pacc_pkg::SHORT_TIMEOUT_RESET;
         playing_ff <= 1'b0;
         cur_priority_ff <= 8'h00;
         volume_ff <= pacc_pkg::DEFAULT_VOLUME;
         elapsed_ff <= 16'd0;
         short_active_ff <= 1'b0;
         rx_count_ff <= 4'd0;
         rx_finish_ff <= 1'b0;
      end else begin
         link_ok_ff <= link_ok_in;
         click_track_ff <= click_track_in;
         click_priority_ff <= click_priority_in;
         long_timeout_ff <= long_timeout_in;
         short_timeout_ff <= short_timeout_in;
         playing_ff <= playing_in;
         cur_priority_ff <= cur_priority_in;
         volume_ff <= volume_in;
         elapsed_ff <= elapsed_in;
         short_active_ff <= short_active_in;
         rx_count_ff <= rx_count_in;
         rx_finish_ff <= rx_finish_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pacc_queue.sv */
`default_nettype none

module pacc_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pacc_pkg::frame_push_type           push,
   output logic                                    room,
   output logic                                    head_valid,
   output pacc_pkg::frame_desc_type                head_desc,
   input  wire logic                               pop,
   output logic [pacc_pkg::QUEUE_CNT_W-1:0]        count
);

   pacc_pkg::frame_desc_type entry_ff [pacc_pkg::QUEUE_DEPTH];

   logic [pacc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pacc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pacc_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [pacc_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
   logic                             do_pop;

   assign wr_ptr_next = wr_ptr_ff + pacc_pkg::QUEUE_PTR_W'(1);
   assign head_valid = (count_ff != '0);
   assign head_desc = entry_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;
   assign room = (count_ff <= pacc_pkg::QUEUE_CNT_W'(pacc_pkg::QUEUE_DEPTH - 2));
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push.valid0 && push.valid1) begin
         wr_ptr_in = wr_ptr_ff + pacc_pkg::QUEUE_PTR_W'(2);
         count_in = count_in + pacc_pkg::QUEUE_CNT_W'(2);
      end else if (push.valid0) begin
         wr_ptr_in = wr_ptr_next;
         count_in = count_in + pacc_pkg::QUEUE_CNT_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + pacc_pkg::QUEUE_PTR_W'(1);
         count_in = count_in - pacc_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entry_ff[wr_ptr_ff] <= push.desc0;
      end
      if (push.valid0 && push.valid1) begin
         entry_ff[wr_ptr_next] <= push.desc1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pacc_back.sv */
`default_nettype none

module pacc_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire pacc_pkg::frame_desc_type head_desc,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output pacc_pkg::rsp_word_type        rsp_word
);

   logic                     busy_ff, busy_in;
   logic [3:0]               idx_ff, idx_in;
   pacc_pkg::frame_desc_type desc_ff, desc_in;
   logic [15:0]              cs_ff, cs_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pacc_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;

   logic       load_out;
   logic       step;
   logic       final_byte;
   logic [7:0] cur_byte;

   assign load_out = !rsp_valid_ff || rsp_ready;
   assign step = busy_ff && load_out;
   assign final_byte = step && (idx_ff == pacc_pkg::FRAME_LAST_INDEX);
   assign pop = head_valid && (!busy_ff || final_byte);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   always_comb begin
      unique case (idx_ff)
         4'd0:    cur_byte = pacc_pkg::FRAME_START;
         4'd1:    cur_byte = pacc_pkg::FRAME_VERSION;
         4'd2:    cur_byte = pacc_pkg::FRAME_LENGTH;
         4'd3:    cur_byte = desc_ff.cmd;
         4'd4:    cur_byte = pacc_pkg::FRAME_FEEDBACK;
         4'd5:    cur_byte = 8'h00;
         4'd6:    cur_byte = desc_ff.lsb;
         4'd7:    cur_byte = cs_ff[15:8];
         4'd8:    cur_byte = cs_ff[7:0];
         default: cur_byte = pacc_pkg::FRAME_END;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      desc_in = desc_ff;
      cs_in = cs_ff;
      if (final_byte) begin
         busy_in = 1'b0;
      end else if (step) begin
         idx_in = idx_ff + 4'd1;
      end
      if (pop) begin
         busy_in = 1'b1;
         idx_in = 4'd0;
         desc_in = head_desc;
         cs_in = pacc_pkg::frame_checksum(head_desc.cmd, head_desc.lsb);
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      if (load_out) begin
         rsp_valid_in = busy_ff;
         rsp_word_in.tx_byte = cur_byte;
         rsp_word_in.last = desc_ff.last && (idx_ff == pacc_pkg::FRAME_LAST_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      cs_ff <= cs_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/priority_audio_cue_command_controller.sv */
// Command controller for a serial audio-player module.
// Events arrive as words on the req_ channel (valid/ready) and are handled in
// order; each command frame leaves as ten words on the rsp_ channel, one byte
// per word, with last set on the final byte produced for an event.
// The front end updates playback state and accepts one word per cycle while
// the frame queue has room for two frames; the back end serializes frames at
// one byte per cycle while rsp_ready is high, via a registered output stage.
// A frame goes from the queue to the serializer, then to the output register.
// A preempting play sends a stop frame followed by a play frame.
// Throughput: one byte per cycle while rsp_ready is high, frames back to back.
// Events that produce no frame are handled by the front end alone.
// When rsp_ready is low the output holds and the serializer waits; the queue
// holds up to four frames, and req_ready drops once three are waiting.
// Synchronous reset clears playback state, the queue and the output stage and
// loads the register defaults. Registers on the csr_ port are to be written
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "priority_audio_cue_command_controller_defines.svh"

module priority_audio_cue_command_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pacc_pkg::req_word_type              req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pacc_pkg::rsp_word_type                   rsp_word,
   input  wire logic                                csr_write_en,
   input  wire logic [pacc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pacc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pacc_pkg::frame_push_type          push;
   pacc_pkg::frame_desc_type          head_desc;
   logic                              queue_room;
   logic                              head_valid;
   logic                              pop;
   logic [pacc_pkg::QUEUE_CNT_W-1:0]  q_count;

   pacc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_room   (queue_room),
      .push         (push)
   );

   pacc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (queue_room),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .count      (q_count)
   );

   pacc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   `PACC_ASSERT_IMPLIES(a_pair_order, clock, reset, push.valid1,
      push.valid0 && !push.desc0.last && push.desc1.last)
   `PACC_ASSERT_IMPLIES(a_no_overflow, clock, reset, push.valid0,
      q_count <= pacc_pkg::QUEUE_CNT_W'(pacc_pkg::QUEUE_DEPTH - 2))
   `PACC_ASSERT_NEXT(a_push_lands, clock, reset, push.valid0 && !pop,
      q_count != '0)

endmodule

`default_nettype wire

/* tb/sv/priority_audio_cue_command_controller_tb.sv */
`timescale 1ns / 100ps

module priority_audio_cue_command_controller_tb;

   localparam logic [2:0] OP_UNUSED_LOW  = 3'd6;
   localparam logic [2:0] OP_UNUSED_HIGH = 3'd7;

   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASES         = 9;
   localparam int PHASE_EVENTS   = 40;
   localparam int PRESSURE_PHASE = 2;
   localparam int MUTE_PHASE     = 3;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      ROW_EVENT,
      ROW_TYPED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   code;
      logic [7:0]   a;
      logic [7:0]   b;
      logic [15:0]  data;
      logic [1:0]   frames;
      logic [7:0]   cmd;
      logic [7:0]   lsb;
   } script_row_type;

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] cmd0;
      logic [7:0] lsb0;
      logic [7:0] cmd1;
      logic [7:0] lsb1;
   } frame_plan_type;

   typedef struct packed {
      logic        link_ok;
      logic [7:0]  click_track;
      logic [7:0]  click_prio;
      logic [15:0] long_to;
      logic [15:0] short_to;
   } cue_cfg_type;

   // The directed script: a stop, a play and a volume while the link is absent, muting,
   // clamping, equal and higher priority, a finish frame, and the shortest timeouts.
   localparam script_row_type SCRIPT [30] = '{
      '{ROW_TYPED, pacc_pkg::OP_STOP, 8'h00, 8'h00, 16'h0000, 2'd1, pacc_pkg::CMD_STOP, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_PLAY, 8'h05, 8'h03, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_VOLUME, 8'hFF, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, pacc_pkg::CSR_LINK_OK, 8'h00, 8'h00, 16'h0001, 2'd0, 8'h00, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_VOLUME, 8'h00, 8'h00, 16'h0000, 2'd1,
        pacc_pkg::CMD_VOLUME, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_PLAY, 8'hFF, 8'hFF, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_CLICK, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_VOLUME, 8'h1F, 8'h00, 16'h0000, 2'd1,
        pacc_pkg::CMD_VOLUME, 8'h1E},
      '{ROW_TYPED, pacc_pkg::OP_PLAY, 8'hFF, 8'h00, 16'h0000, 2'd1, pacc_pkg::CMD_PLAY, 8'hFF},
      '{ROW_TYPED, pacc_pkg::OP_PLAY, 8'h07, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_PLAY, 8'h00, 8'hFF, 16'h0000, 2'd2, pacc_pkg::CMD_PLAY, 8'h00},
      '{ROW_TYPED, pacc_pkg::OP_CLICK, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'h7E, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'hFF, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'h06, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'h3D, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'h01, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'hFE, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'hBD, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_RX, 8'hEF, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, pacc_pkg::CSR_CLICK_TRACK, 8'h00, 8'h00, 16'h0080, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, pacc_pkg::CSR_SHORT_TIMEOUT, 8'h00, 8'h00, 16'h0001, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_CLICK, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, pacc_pkg::CSR_LONG_TIMEOUT, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_PLAY, 8'h2A, 8'h10, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00},
      '{ROW_EVENT, pacc_pkg::OP_CLICK, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00}
   };

   logic                             clock;
   logic                             reset        = 1'b1;
   logic                             req_valid    = 1'b0;
   logic                             req_ready;
   pacc_pkg::req_word_type           req_word     = '0;
   logic                             rsp_valid;
   logic                             rsp_ready    = 1'b0;
   pacc_pkg::rsp_word_type           rsp_word;
   logic                             csr_write_en = 1'b0;
   logic [pacc_pkg::CSR_INDEX_W-1:0] csr_index    = '0;
   logic [pacc_pkg::CSR_DATA_W-1:0]  csr_wdata    = '0;

   cue_cfg_type  cfg;
   logic         pb_playing;
   logic [7:0]   pb_priority;
   logic [4:0]   pb_volume;
   logic [15:0]  pb_elapsed;
   logic         pb_short;
   logic [3:0]   rx_pos;
   logic         rx_finish;

   pacc_pkg::rsp_word_type expected_bytes[$];
   int           error_count     = 0;
   int           bytes_checked   = 0;
   int           events_sent     = 0;
   int           preemptions     = 0;
   int           timeout_ends    = 0;
   int           finish_ends     = 0;
   int           cycles_run      = 0;
   int           sender_calm     = 0;
   bit           sender_no_gaps  = 1'b0;
   bit           hold_pending    = 1'b0;

   priority_audio_cue_command_controller i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
   end

   initial begin : watchdog
      wait (cycles_run >= CYCLE_LIMIT);
      $display("priority_audio_cue_command_controller_tb: errors");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [15:0] pick_timeout();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'hFFFF;
      if (r < 20) return 16'd1;
      if (r < 25) return 16'd0;
      return 16'($urandom_range(2, 40));
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 8'h00;
      if (r < 4) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic pacc_pkg::req_word_type make_word(input logic [2:0] op);
      pacc_pkg::req_word_type w;
      w.op           = op;
      w.track        = 8'($urandom_range(0, 255));
      w.priority_req = 8'($urandom_range(0, 255));
      w.level        = 8'($urandom_range(0, 255));
      w.rx_byte      = 8'($urandom_range(0, 255));
      return w;
   endfunction

   task automatic reset_model();
      cfg.link_ok     = 1'b0;
      cfg.click_track = pacc_pkg::CLICK_TRACK_RESET;
      cfg.click_prio  = 8'h00;
      cfg.long_to     = pacc_pkg::LONG_TIMEOUT_RESET;
      cfg.short_to    = pacc_pkg::SHORT_TIMEOUT_RESET;
      pb_playing      = 1'b0;
      pb_priority     = 8'h00;
      pb_volume       = pacc_pkg::DEFAULT_VOLUME;
      pb_elapsed      = 16'h0000;
      pb_short        = 1'b0;
      rx_pos          = 4'd0;
      rx_finish       = 1'b0;
   endtask

   function automatic frame_plan_type predict_event(input pacc_pkg::req_word_type w);
      frame_plan_type plan;
      logic [15:0]    limit;
      plan = '0;
      case (w.op)
         pacc_pkg::OP_PLAY: begin
            if (cfg.link_ok && pb_volume != 5'd0) begin
               pb_short = 1'b0;
               if (!pb_playing || w.priority_req > pb_priority) begin
                  if (pb_playing) begin
                     plan.count = 2'd2;
                     plan.cmd0  = pacc_pkg::CMD_STOP;
                     plan.cmd1  = pacc_pkg::CMD_PLAY;
                     plan.lsb1  = w.track;
                     preemptions++;
                  end else begin
                     plan.count = 2'd1;
                     plan.cmd0  = pacc_pkg::CMD_PLAY;
                     plan.lsb0  = w.track;
                  end
                  pb_playing  = 1'b1;
                  pb_priority = w.priority_req;
                  pb_elapsed  = 16'h0000;
               end
            end
         end
         pacc_pkg::OP_CLICK: begin
            if (cfg.link_ok && pb_volume != 5'd0 && !pb_playing) begin
               plan.count  = 2'd1;
               plan.cmd0   = pacc_pkg::CMD_PLAY;
               plan.lsb0   = cfg.click_track;
               pb_playing  = 1'b1;
               pb_priority = cfg.click_prio;
               pb_elapsed  = 16'h0000;
               pb_short    = 1'b1;
            end
         end
         pacc_pkg::OP_STOP: begin
            plan.count  = 2'd1;
            plan.cmd0   = pacc_pkg::CMD_STOP;
            pb_playing  = 1'b0;
            pb_priority = 8'h00;
         end
         pacc_pkg::OP_VOLUME: begin
            pb_volume = (w.level > {3'b000, pacc_pkg::VOLUME_MAX}) ?
                        pacc_pkg::VOLUME_MAX : w.level[4:0];
            if (cfg.link_ok) begin
               plan.count = 2'd1;
               plan.cmd0  = pacc_pkg::CMD_VOLUME;
               plan.lsb0  = {3'b000, pb_volume};
            end
         end
         pacc_pkg::OP_TICK: begin
            if (pb_playing) begin
               limit = pb_short ? cfg.short_to : cfg.long_to;
               if (pb_elapsed != 16'hFFFF) pb_elapsed = pb_elapsed + 16'd1;
               if (pb_elapsed >= limit) begin
                  pb_playing  = 1'b0;
                  pb_priority = 8'h00;
                  timeout_ends++;
               end
            end
         end
         pacc_pkg::OP_RX: begin
            if (rx_pos == 4'd0) begin
               if (w.rx_byte == pacc_pkg::FRAME_START) begin
                  rx_pos    = 4'd1;
                  rx_finish = 1'b0;
               end
            end else begin
               if (rx_pos == pacc_pkg::RX_BODY_CMD) begin
                  rx_finish = (w.rx_byte == pacc_pkg::CMD_FINISH);
               end
               if (rx_pos >= pacc_pkg::RX_BODY_LAST) begin
                  if (rx_finish) begin
                     if (pb_playing) finish_ends++;
                     pb_playing  = 1'b0;
                     pb_priority = 8'h00;
                  end
                  rx_pos    = 4'd0;
                  rx_finish = 1'b0;
               end else begin
                  rx_pos = rx_pos + 4'd1;
               end
            end
         end
         default: begin
         end
      endcase
      return plan;
   endfunction

   task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] lsb, input logic last);
      logic [15:0]            chk;
      logic [7:0]             frame [10];
      pacc_pkg::rsp_word_type item;
      chk = 16'h0000 - ({8'h00, pacc_pkg::FRAME_VERSION} + {8'h00, pacc_pkg::FRAME_LENGTH}
                        + {8'h00, cmd} + {8'h00, lsb});
      frame = '{pacc_pkg::FRAME_START, pacc_pkg::FRAME_VERSION, pacc_pkg::FRAME_LENGTH, cmd,
                pacc_pkg::FRAME_FEEDBACK, 8'h00, lsb, chk[15:8], chk[7:0],
                pacc_pkg::FRAME_END};
      for (int i = 0; i < 10; i++) begin
         item.tx_byte = frame[i];
         item.last    = last && (i == 9);
         expected_bytes.push_back(item);
      end
   endtask

   task automatic offer(input pacc_pkg::req_word_type w);
      int gap;
      if (sender_no_gaps) begin
         gap = 0;
      end else if (sender_calm != 0) begin
         sender_calm--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 99) < 4) sender_calm = $urandom_range(20, 60);
         gap = gap_len();
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_event(input pacc_pkg::req_word_type w, input bit typed,
                             input frame_plan_type given);
      frame_plan_type plan;
      offer(w);
      plan = predict_event(w);
      if (typed) plan = given;
      if (plan.count != 2'd0) queue_frame(plan.cmd0, plan.lsb0, plan.count == 2'd1);
      if (plan.count == 2'd2) queue_frame(plan.cmd1, plan.lsb1, 1'b1);
      events_sent++;
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pacc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [pacc_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      case (index)
         pacc_pkg::CSR_LINK_OK:        cfg.link_ok     = data[0];
         pacc_pkg::CSR_CLICK_TRACK:    cfg.click_track = data[7:0];
         pacc_pkg::CSR_CLICK_PRIORITY: cfg.click_prio  = data[7:0];
         pacc_pkg::CSR_LONG_TIMEOUT:   cfg.long_to     = data;
         pacc_pkg::CSR_SHORT_TIMEOUT:  cfg.short_to    = data;
         default: begin
         end
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_script_row(input script_row_type row);
      pacc_pkg::req_word_type w;
      frame_plan_type         given;
      if (row.kind == ROW_CSR) begin
         drain(SETTLE_CYCLES);
         write_csr(row.code, row.data);
      end else begin
         w = make_word(row.code);
         case (row.code)
            pacc_pkg::OP_PLAY: begin
               w.track        = row.a;
               w.priority_req = row.b;
            end
            pacc_pkg::OP_VOLUME: w.level   = row.a;
            pacc_pkg::OP_RX:     w.rx_byte = row.a;
            default: begin
            end
         endcase
         given       = '0;
         given.count = row.frames;
         if (row.frames == 2'd2) begin
            given.cmd0 = pacc_pkg::CMD_STOP;
            given.cmd1 = row.cmd;
            given.lsb1 = row.lsb;
         end else begin
            given.cmd0 = row.cmd;
            given.lsb0 = row.lsb;
         end
         send_event(w, row.kind == ROW_TYPED, given);
      end
   endtask

   task automatic random_phase(input bit pressure);
      int                     done;
      int                     r;
      int                     n;
      bit                     finish;
      pacc_pkg::req_word_type w;
      done = 0;
      while (done < PHASE_EVENTS) begin
         r = $urandom_range(0, 99);
         if (pressure) begin
            w = make_word(r < 40 ? pacc_pkg::OP_STOP :
                          (r < 75 ? pacc_pkg::OP_VOLUME : pacc_pkg::OP_PLAY));
            send_event(w, 1'b0, '0);
            done++;
         end else if (r < 14) begin
            send_event(make_word(pacc_pkg::OP_PLAY), 1'b0, '0);
            done++;
         end else if (r < 24) begin
            send_event(make_word(pacc_pkg::OP_CLICK), 1'b0, '0);
            done++;
         end else if (r < 30) begin
            send_event(make_word(pacc_pkg::OP_STOP), 1'b0, '0);
            done++;
         end else if (r < 38) begin
            w = make_word(pacc_pkg::OP_VOLUME);
            n = $urandom_range(0, 9);
            if (n == 0) w.level = 8'h00;
            else if (n < 6) w.level = 8'($urandom_range(1, 30));
            send_event(w, 1'b0, '0);
            done++;
         end else if (r < 60) begin
            n = $urandom_range(1, 12);
            repeat (n) send_event(make_word(pacc_pkg::OP_TICK), 1'b0, '0);
            done += n;
         end else if (r < 85) begin
            finish = ($urandom_range(0, 9) < 7);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 10;
            for (int i = 0; i < n; i++) begin
               w = make_word(pacc_pkg::OP_RX);
               if (i == 0) w.rx_byte = pacc_pkg::FRAME_START;
               else if (i == pacc_pkg::RX_BODY_CMD && finish) w.rx_byte = pacc_pkg::CMD_FINISH;
               send_event(w, 1'b0, '0);
            end
            done += n;
         end else if (r < 95) begin
            n = $urandom_range(1, 3);
            repeat (n) send_event(make_word(pacc_pkg::OP_RX), 1'b0, '0);
            done += n;
         end else begin
            send_event(make_word(r < 98 ? OP_UNUSED_LOW : OP_UNUSED_HIGH), 1'b0, '0);
            done++;
         end
      end
   endtask

   initial begin : receiver
      int stall_left;
      int calm_left;
      int hold_left;
      stall_left = 0;
      calm_left  = 0;
      hold_left  = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left != 0) begin
               calm_left--;
            end else if ($urandom_range(0, 99) < 3) begin
               calm_left = $urandom_range(40, 120);
            end else begin
               stall_left = gap_len();
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      pacc_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("unexpected word: byte %02h last %0b", rsp_word.tx_byte, rsp_word.last);
            end
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_word.tx_byte !== want.tx_byte || rsp_word.last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("word mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                           want.tx_byte, want.last, rsp_word.tx_byte, rsp_word.last);
               end
            end
         end
      end
   end

   initial begin : sequencer
      cue_cfg_type phase_cfg;
      reset_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 30; i++) run_script_row(SCRIPT[i]);

      for (int p = 0; p < PHASES; p++) begin
         drain(SETTLE_CYCLES);
         phase_cfg.link_ok     = (p != MUTE_PHASE);
         phase_cfg.click_track = pick_byte();
         phase_cfg.click_prio  = pick_byte();
         phase_cfg.long_to     = pick_timeout();
         phase_cfg.short_to    = pick_timeout();
         if (p == 0) begin
            phase_cfg = '{1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF};
         end else if (p == 1) begin
            phase_cfg = '{1'b1, 8'h00, 8'h00, 16'd1, 16'd1};
         end
         write_csr(pacc_pkg::CSR_LINK_OK, {15'd0, phase_cfg.link_ok});
         write_csr(pacc_pkg::CSR_CLICK_TRACK, {8'd0, phase_cfg.click_track});
         write_csr(pacc_pkg::CSR_CLICK_PRIORITY, {8'd0, phase_cfg.click_prio});
         write_csr(pacc_pkg::CSR_LONG_TIMEOUT, phase_cfg.long_to);
         write_csr(pacc_pkg::CSR_SHORT_TIMEOUT, phase_cfg.short_to);
         sender_no_gaps = (p == PRESSURE_PHASE);
         if (p == PRESSURE_PHASE) hold_pending = 1'b1;
         random_phase(p == PRESSURE_PHASE);
      end

      drain(SETTLE_CYCLES);
      $display("Run covered %0d events over %0d configurations, %0d frame bytes compared.",
               events_sent, PHASES + 1, bytes_checked);
      $display("Playback ended by %0d preemptions, %0d timeouts and %0d finish frames.",
               preemptions, timeout_ends, finish_ends);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("priority_audio_cue_command_controller_tb: clean");
      end else begin
         $display("priority_audio_cue_command_controller_tb: errors");
      end
      $finish;
   end

endmodule
